FILE: sv/thick_stroke_quad_expander_unit_assert.svh
// Assertion macros for the thick stroke quad expander.
// Included by the top level; needs clk and arst_n in scope at the point of use.
`ifndef THICK_STROKE_QUAD_EXPANDER_UNIT_ASSERT_SVH
`define THICK_STROKE_QUAD_EXPANDER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define TSQE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("tsqe assertion failed");
`define TSQE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tsqe assertion failed");
`else
`define TSQE_ASSERT(lbl, prop)
`define TSQE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: sv/tsqe_pkg.sv
// Shared types, constants and helper functions of the thick stroke quad expander.
// No dependencies.
package tsqe_pkg;

	localparam int COORD_W = 24;
	localparam int COLOR_W = 32;
	localparam int THICK_W = 16;
	localparam logic [THICK_W-1:0] THICK_RESET = 16'd256;
	localparam int DEF_COORD_FRAC_BITS = 8;
	localparam int THICK_FRAC_BITS = 8;
	localparam int CLICK_SH = THICK_FRAC_BITS + 1;
	localparam int DIFF_W = COORD_W + 1;
	localparam int SQ_W = 2 * DIFF_W;
	localparam int ROOT_W = DIFF_W;
	localparam int QUOT_EXTRA = 10;
	localparam int WIDE_W = 48;

	localparam logic signed [WIDE_W-1:0] WIDE_MAX = (WIDE_W'(1) <<< (COORD_W - 1)) - 1;
	localparam logic signed [WIDE_W-1:0] WIDE_MIN = -WIDE_MAX - 1;

	typedef enum logic [3:0] {
		S_IDLE, S_STORE, S_MXX, S_MYY, S_SQA, S_SQI, S_SQ, S_SQF,
		S_MN, S_DVI, S_DV, S_DVF, S_EMIT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_STORE, OP_MXX, OP_MYY, OP_SQA, OP_SQI, OP_SQS,
		OP_SQF, OP_MN, OP_DVI, OP_DVS, OP_DVF, OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_A, C_B, C_C, C_D, C_LL, C_HL, C_HH, C_LH
	} corner_t;

	typedef struct packed {
		op_t op;
		logic axis;
		corner_t corner;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic seg_zero;
		logic out_free;
	} status_t;

	function automatic logic signed [COORD_W-1:0] sat_coord(
		input logic signed [WIDE_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > WIDE_MAX) begin
			r = COORD_W'(WIDE_MAX);
		end else if (v < WIDE_MIN) begin
			r = COORD_W'(WIDE_MIN);
		end else begin
			r = COORD_W'(v);
		end
		return r;
	endfunction

endpackage

FILE: sv/tsqe_ctrl.sv
// Sequencing state machine of the thick stroke quad expander.
// Depends on tsqe_pkg; drives the datapath through cmd_t and reads status_t.
module tsqe_ctrl import tsqe_pkg::*; #(
	parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    req_type,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam int QUOT_W = COORD_FRAC_BITS + QUOT_EXTRA;
	localparam int ITER_MAX = (ROOT_W > QUOT_W) ? ROOT_W : QUOT_W;
	localparam int CNT_W = $clog2(ITER_MAX + 1);

	state_t state_q, state_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [2:0] k_q, k_n;
	logic axis_q, axis_n;
	logic click_q, click_n;
	logic await_q, await_n;
	logic any_q, any_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			k_q <= '0;
			axis_q <= 1'b0;
			click_q <= 1'b0;
			await_q <= 1'b1;
			any_q <= 1'b0;
		end else begin
			state_q <= state_n;
			cnt_q <= cnt_n;
			k_q <= k_n;
			axis_q <= axis_n;
			click_q <= click_n;
			await_q <= await_n;
			any_q <= any_n;
		end
	end

	always_comb begin
		state_n = state_q;
		cnt_n = cnt_q;
		k_n = k_q;
		axis_n = axis_q;
		click_n = click_q;
		await_n = await_q;
		any_n = any_q;
		in_ready = 1'b0;
		cmd.op = OP_NONE;
		cmd.axis = axis_q;
		cmd.last = click_q ? (k_q == 3'd3) : (k_q == 3'd7);
		if (click_q) begin
			case (k_q[1:0])
				2'd0: cmd.corner = C_LL;
				2'd1: cmd.corner = C_HL;
				2'd2: cmd.corner = C_HH;
				default: cmd.corner = C_LH;
			endcase
		end else begin
			// Counter values 0..3 give the bridge and start pair, 4..7 the end pair twice.
			if (k_q[2]) begin
				cmd.corner = k_q[0] ? C_D : C_C;
			end else begin
				cmd.corner = k_q[0] ? C_B : C_A;
			end
		end
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					if (req_type) begin
						click_n = 1'b1;
						k_n = 3'd0;
						state_n = S_EMIT;
					end else if (await_q) begin
						state_n = S_STORE;
					end else begin
						state_n = S_MXX;
					end
				end
			end
			S_STORE: begin
				cmd.op = OP_STORE;
				await_n = 1'b0;
				state_n = S_IDLE;
			end
			S_MXX: begin
				if (status.seg_zero) begin
					state_n = S_IDLE;
				end else begin
					cmd.op = OP_MXX;
					state_n = S_MYY;
				end
			end
			S_MYY: begin
				cmd.op = OP_MYY;
				state_n = S_SQA;
			end
			S_SQA: begin
				cmd.op = OP_SQA;
				state_n = S_SQI;
			end
			S_SQI: begin
				cmd.op = OP_SQI;
				cnt_n = CNT_W'(ROOT_W - 1);
				state_n = S_SQ;
			end
			S_SQ: begin
				cmd.op = OP_SQS;
				if (cnt_q == '0) begin
					state_n = S_SQF;
				end else begin
					cnt_n = cnt_q - 1'b1;
				end
			end
			S_SQF: begin
				cmd.op = OP_SQF;
				axis_n = 1'b0;
				state_n = S_MN;
			end
			S_MN: begin
				cmd.op = OP_MN;
				state_n = S_DVI;
			end
			S_DVI: begin
				cmd.op = OP_DVI;
				cnt_n = CNT_W'(QUOT_W - 1);
				state_n = S_DV;
			end
			S_DV: begin
				cmd.op = OP_DVS;
				if (cnt_q == '0) begin
					state_n = S_DVF;
				end else begin
					cnt_n = cnt_q - 1'b1;
				end
			end
			S_DVF: begin
				cmd.op = OP_DVF;
				if (!axis_q) begin
					axis_n = 1'b1;
					state_n = S_MN;
				end else begin
					click_n = 1'b0;
					k_n = any_q ? 3'd0 : 3'd2;
					state_n = S_EMIT;
				end
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.op = OP_EMIT;
					if (cmd.last) begin
						any_n = 1'b1;
						if (!click_q) begin
							await_n = 1'b1;
						end
						state_n = S_IDLE;
					end else begin
						k_n = k_q + 1'b1;
					end
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/tsqe_dp.sv
// Datapath of the thick stroke quad expander: multiplier, square root and divider
// registers, corner arithmetic and the output register. Depends on tsqe_pkg.
module tsqe_dp import tsqe_pkg::*; #(
	parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output status_t                   status,
	input  logic                      cfg_wr_en,
	input  logic [THICK_W-1:0]        cfg_wr_data,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic [COLOR_W-1:0]        color,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] vert_x,
	output logic signed [COORD_W-1:0] vert_y,
	output logic [COLOR_W-1:0]        vert_color,
	output logic                      last
);

	localparam int TW = THICK_W + COORD_FRAC_BITS;
	localparam int MB_W = (TW > DIFF_W) ? TW : DIFF_W;
	localparam int PW = DIFF_W + MB_W;
	localparam int NW = PW + 1 - CLICK_SH;
	localparam int QUOT_W = COORD_FRAC_BITS + QUOT_EXTRA;
	localparam int OW = QUOT_W + 1;
	localparam int RW = ROOT_W + 2;

	logic [THICK_W-1:0] thick_q;
	logic signed [COORD_W-1:0] px_q, py_q, stx_q, sty_q;
	logic [COLOR_W-1:0] col_q;
	logic signed [DIFF_W-1:0] dx_q, dy_q;
	logic [PW-1:0] prod_q;
	logic [SQ_W-1:0] acc_q, rad_q;
	logic [RW-1:0] srem_q;
	logic [ROOT_W-1:0] root_q, mag_q, drem_q;
	logic [QUOT_W-1:0] dsh_q;
	logic neg_q;
	logic signed [OW-1:0] ox_q, oy_q;
	logic out_valid_q, out_last_q;
	logic signed [COORD_W-1:0] out_x_q, out_y_q;
	logic [COLOR_W-1:0] out_col_q;

	logic [TW-1:0] t_val;
	logic [DIFF_W-1:0] adx, ady;
	logic [DIFF_W-1:0] mul_a;
	logic [MB_W-1:0] mul_b;
	logic [PW-1:0] prod_n;
	logic [RW+1:0] sq_sh, sq_trial;
	logic [PW:0] nsum;
	logic [NW-1:0] nval;
	logic [ROOT_W:0] dv_sh;
	logic signed [OW-1:0] qv;
	logic signed [WIDE_W-1:0] t_wide, vx_w, vy_w;

	function automatic logic signed [WIDE_W-1:0] round_den(
		input logic signed [WIDE_W-1:0] num);
		logic [WIDE_W-1:0] a, q;
		a = num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
		q = (a + (WIDE_W'(1) << THICK_FRAC_BITS)) >> CLICK_SH;
		return num[WIDE_W-1] ? -signed'(q) : signed'(q);
	endfunction

	assign t_val = TW'(thick_q) << COORD_FRAC_BITS;
	assign t_wide = signed'(WIDE_W'(t_val));
	assign adx = dx_q[DIFF_W-1] ? DIFF_W'(-dx_q) : DIFF_W'(dx_q);
	assign ady = dy_q[DIFF_W-1] ? DIFF_W'(-dy_q) : DIFF_W'(dy_q);

	always_comb begin
		case (cmd.op)
			OP_MXX: begin
				mul_a = adx;
				mul_b = MB_W'(adx);
			end
			OP_MYY: begin
				mul_a = ady;
				mul_b = MB_W'(ady);
			end
			default: begin
				mul_a = cmd.axis ? adx : ady;
				mul_b = MB_W'(t_val);
			end
		endcase
	end
	assign prod_n = PW'(mul_a) * PW'(mul_b);

	assign sq_sh = {srem_q, rad_q[SQ_W-1 -: 2]};
	assign sq_trial = (RW+2)'({root_q, 2'b01});
	// Round to nearest: (a + 256*mag) / (512*mag) taken as a shift, then a divide by mag.
	assign nsum = (PW+1)'(prod_q) + ((PW+1)'(mag_q) << THICK_FRAC_BITS);
	assign nval = NW'(nsum >> CLICK_SH);
	assign dv_sh = {drem_q, dsh_q[QUOT_W-1]};
	assign qv = signed'({1'b0, dsh_q});

	always_comb begin
		case (cmd.corner)
			C_A: begin
				vx_w = WIDE_W'(stx_q) - WIDE_W'(ox_q);
				vy_w = WIDE_W'(sty_q) - WIDE_W'(oy_q);
			end
			C_B: begin
				vx_w = WIDE_W'(stx_q) + WIDE_W'(ox_q);
				vy_w = WIDE_W'(sty_q) + WIDE_W'(oy_q);
			end
			C_C: begin
				vx_w = WIDE_W'(px_q) + WIDE_W'(ox_q);
				vy_w = WIDE_W'(py_q) + WIDE_W'(oy_q);
			end
			C_D: begin
				vx_w = WIDE_W'(px_q) - WIDE_W'(ox_q);
				vy_w = WIDE_W'(py_q) - WIDE_W'(oy_q);
			end
			C_LL: begin
				vx_w = round_den((WIDE_W'(px_q) <<< CLICK_SH) - t_wide);
				vy_w = round_den((WIDE_W'(py_q) <<< CLICK_SH) - t_wide);
			end
			C_HL: begin
				vx_w = round_den((WIDE_W'(px_q) <<< CLICK_SH) + t_wide);
				vy_w = round_den((WIDE_W'(py_q) <<< CLICK_SH) - t_wide);
			end
			C_HH: begin
				vx_w = round_den((WIDE_W'(px_q) <<< CLICK_SH) + t_wide);
				vy_w = round_den((WIDE_W'(py_q) <<< CLICK_SH) + t_wide);
			end
			default: begin
				vx_w = round_den((WIDE_W'(px_q) <<< CLICK_SH) - t_wide);
				vy_w = round_den((WIDE_W'(py_q) <<< CLICK_SH) + t_wide);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thick_q <= THICK_RESET;
			stx_q <= '0;
			sty_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				thick_q <= cfg_wr_data;
			end
			if (cmd.op == OP_STORE) begin
				stx_q <= px_q;
				sty_q <= py_q;
			end
			if (cmd.op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				px_q <= pos_x;
				py_q <= pos_y;
				col_q <= color;
				dx_q <= DIFF_W'(stx_q) - DIFF_W'(pos_x);
				dy_q <= DIFF_W'(sty_q) - DIFF_W'(pos_y);
			end
			OP_MXX: begin
				prod_q <= prod_n;
			end
			OP_MYY: begin
				acc_q <= prod_q[SQ_W-1:0];
				prod_q <= prod_n;
			end
			OP_SQA: begin
				acc_q <= acc_q + prod_q[SQ_W-1:0];
			end
			OP_SQI: begin
				rad_q <= acc_q;
				srem_q <= '0;
				root_q <= '0;
			end
			OP_SQS: begin
				rad_q <= rad_q << 2;
				if (sq_sh >= sq_trial) begin
					srem_q <= RW'(sq_sh - sq_trial);
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					srem_q <= RW'(sq_sh);
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			OP_SQF: begin
				// The remainder beyond the root means the true root lies above r + 1/2.
				mag_q <= (srem_q > RW'(root_q)) ? root_q + 1'b1 : root_q;
			end
			OP_MN: begin
				prod_q <= prod_n;
				neg_q <= cmd.axis ? dx_q[DIFF_W-1] : ~dy_q[DIFF_W-1];
			end
			OP_DVI: begin
				drem_q <= ROOT_W'(nval >> QUOT_W);
				dsh_q <= nval[QUOT_W-1:0];
			end
			OP_DVS: begin
				if (dv_sh >= {1'b0, mag_q}) begin
					drem_q <= ROOT_W'(dv_sh - {1'b0, mag_q});
					dsh_q <= {dsh_q[QUOT_W-2:0], 1'b1};
				end else begin
					drem_q <= ROOT_W'(dv_sh);
					dsh_q <= {dsh_q[QUOT_W-2:0], 1'b0};
				end
			end
			OP_DVF: begin
				if (cmd.axis) begin
					oy_q <= neg_q ? -qv : qv;
				end else begin
					ox_q <= neg_q ? -qv : qv;
				end
			end
			OP_EMIT: begin
				out_x_q <= sat_coord(vx_w);
				out_y_q <= sat_coord(vy_w);
				out_col_q <= col_q;
				out_last_q <= cmd.last;
			end
			default: begin
			end
		endcase
	end

	assign status.seg_zero = (dx_q == '0) && (dy_q == '0);
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign vert_x = out_x_q;
	assign vert_y = out_y_q;
	assign vert_color = out_col_q;
	assign last = out_last_q;

endmodule

FILE: sv/thick_stroke_quad_expander_unit.sv
// Top level of the thick stroke quad expander: joins controller and datapath.
// Depends on tsqe_pkg, tsqe_ctrl, tsqe_dp and the assertion macro header.
//
// Takes one pen point at a time and returns quad vertices through an output register,
// so the next point is taken while the final vertex still waits. A click sends four
// vertices, a first drag point is stored as the segment start, and a repeated drag
// point is dropped. A segment runs through 25 square root steps, then two restoring
// divides of COORD_FRAC_BITS + 10 steps each on the shared divider registers, then
// sends six or eight vertices.
`include "thick_stroke_quad_expander_unit_assert.svh"

module thick_stroke_quad_expander_unit import tsqe_pkg::*; #(
	parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [THICK_W-1:0]        cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      req_type,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic [COLOR_W-1:0]        color,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] vert_x,
	output logic signed [COORD_W-1:0] vert_y,
	output logic [COLOR_W-1:0]        vert_color,
	output logic                      last
);

	cmd_t cmd;
	status_t status;

	tsqe_ctrl #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.req_type(req_type),
		.in_ready(in_ready),
		.status(status),
		.cmd(cmd)
	);

	tsqe_dp #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.color(color),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.vert_x(vert_x),
		.vert_y(vert_y),
		.vert_color(vert_color),
		.last(last)
	);

	// A vertex is only written when the output register is free.
	`TSQE_ASSERT(a_emit_free, (cmd.op != OP_EMIT) || status.out_free)
	// No new point is taken while vertices of the current one are being sent.
	`TSQE_ASSERT(a_emit_busy, (cmd.op != OP_EMIT) || !in_ready)
	// Input registers load only on an input transfer.
	`TSQE_ASSERT(a_load_xfer, (cmd.op != OP_LOAD) || (in_valid && in_ready))
	// A written vertex shows up as valid on the next cycle.
	`TSQE_ASSERT_NEXT(a_emit_shows, cmd.op == OP_EMIT, out_valid)

endmodule
